/* hw/rtl/smt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and codes for the sum tree slot store.
// ----------------------------------------------------------------------------
package smt_pkg;

	localparam logic signed [31:0] FREE_MARK = 32'sd1;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_PATH = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_MISSING = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_LEAF,
		ST_SIB_RD,
		ST_SIB_ADD
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] leaf_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         leaf_index;
		logic signed [31:0] root_sum;
		logic signed [31:0] left_value;
		logic signed [31:0] right_value;
		logic signed [31:0] parent_value;
		logic               path_is_right;
		logic               last;
	} out_beat_t;

	// Result of the shared compare and add unit.
	typedef struct packed {
		logic               eq;
		logic signed [31:0] sum;
	} alu_res_t;

endpackage
`default_nettype wire

/* hw/rtl/smt_node_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smt_node_mem
// Node storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smt_node_mem #(
	parameter int AW    = 5,
	parameter int DEPTH = 31
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic signed [31:0]    wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output logic signed [31:0]         rdata_q
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/smt_path_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smt_path_alu
// Shared unit: equality compare for the leaf search, wrapping add for sums.
// ----------------------------------------------------------------------------
module smt_path_alu
	import smt_pkg::*;
(
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output alu_res_t                res
);

	assign res.eq  = (a == b);
	assign res.sum = a + b;

endmodule
`default_nettype wire

/* hw/rtl/sum_merkle_tree_slot_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sum_merkle_tree_slot_store
// Fixed depth binary sum tree with add, delete and authentication path reads.
// ----------------------------------------------------------------------------
// A command keeps busy high while it scans the leaves and, on a match, walks
// the path to the root; the last beat is strobed in the first cycle with busy
// low. A miss scans every leaf before its status beat.
// One command at a time. Results are strobed for one cycle; no stall.
// Reset: after arst_n a clearing pass writes the reset tree (leaves one, inner
// nodes child sums); busy is high meanwhile.
// ----------------------------------------------------------------------------
module sum_merkle_tree_slot_store
	import smt_pkg::*;
#(
	parameter int TREE_LEVELS = 5
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  in_beat_t  cmd,
	output logic      result_valid,
	output out_beat_t result
);

	localparam int AW         = TREE_LEVELS;
	localparam int LW         = TREE_LEVELS - 1;
	localparam int LEAF_COUNT = 1 << (TREE_LEVELS - 1);
	localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;

	state_t state_q, state_d;

	// Command context.
	logic [1:0]         op_q;
	logic signed [31:0] value_q;
	logic signed [31:0] target_q;

	// Search pipeline: srch_q issues reads, cmp_idx_q is the leaf whose data
	// is in the read register this cycle.
	logic [AW-1:0] srch_q;
	logic [LW-1:0] cmp_idx_q;
	logic          cmp_vld_q;

	// Path walk: cur_q is the value of the path node at the current level.
	logic [LW-1:0]      leaf_q;
	logic [LW-1:0]      pos_q;
	logic [AW-1:0]      off_q;
	logic [AW-1:0]      cnt_q;
	logic signed [31:0] cur_q;
	logic signed [31:0] root_q;

	// Clearing pass walks every entry, level by level.
	logic [AW-1:0]      clr_addr_q;
	logic [AW-1:0]      clr_end_q;
	logic [AW-1:0]      clr_cnt_q;
	logic signed [31:0] clr_val_q;

	// Memory and shared unit.
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;
	logic signed [31:0] alu_b;
	alu_res_t           alu;

	logic      emit;
	out_beat_t emit_beat;
	logic      found;
	logic      missed;
	logic      top_level;
	logic      clr_done;

	smt_node_mem #(
		.AW    (AW),
		.DEPTH (NODE_COUNT)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	smt_path_alu u_alu (
		.a   (mem_rdata),
		.b   (alu_b),
		.res (alu)
	);

	assign found     = (state_q == ST_SEARCH) && cmp_vld_q && alu.eq;
	assign missed    = (state_q == ST_SEARCH) && cmp_vld_q && !alu.eq && (&cmp_idx_q);
	assign top_level = (cnt_q == AW'(2));
	assign clr_done  = (clr_addr_q == AW'(NODE_COUNT - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && cmd.operation != OP_NONE) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (found) state_d = ST_LEAF;
				else if (missed) state_d = ST_IDLE;
			end
			ST_LEAF: state_d = ST_SIB_RD;
			ST_SIB_RD: state_d = ST_SIB_ADD;
			ST_SIB_ADD: begin
				state_d = top_level ? ST_IDLE : ST_SIB_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory control, operand select and result assembly.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		alu_b     = cur_q;
		emit      = 1'b0;
		emit_beat = '0;
		emit_beat.leaf_index = 4'(leaf_q);
		emit_beat.root_sum   = root_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = clr_val_q;
			end
			ST_SEARCH: begin
				alu_b     = target_q;
				mem_re    = !srch_q[AW-1];
				mem_raddr = srch_q;
				if (missed) begin
					emit                 = 1'b1;
					emit_beat.status     = (op_q == OP_ADD) ? STAT_FULL : STAT_MISSING;
					emit_beat.leaf_index = '0;
					emit_beat.last       = 1'b1;
				end
			end
			ST_LEAF: begin
				mem_we    = (op_q != OP_PATH);
				mem_waddr = AW'(leaf_q);
				mem_wdata = cur_q;
			end
			ST_SIB_RD: begin
				mem_re    = 1'b1;
				mem_raddr = off_q + AW'(pos_q ^ LW'(1));
			end
			ST_SIB_ADD: begin
				mem_we    = (op_q != OP_PATH);
				mem_waddr = off_q + cnt_q + AW'(pos_q >> 1);
				mem_wdata = alu.sum;
				if (op_q == OP_PATH) begin
					// The stored parent always equals the sum of its children.
					emit                    = 1'b1;
					emit_beat.left_value    = pos_q[0] ? mem_rdata : cur_q;
					emit_beat.right_value   = pos_q[0] ? cur_q : mem_rdata;
					emit_beat.parent_value  = alu.sum;
					emit_beat.path_is_right = pos_q[0];
					emit_beat.last          = top_level;
				end else if (top_level) begin
					emit               = 1'b1;
					emit_beat.root_sum = alu.sum;
					emit_beat.last     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			clr_end_q    <= AW'(LEAF_COUNT - 1);
			clr_cnt_q    <= AW'(LEAF_COUNT);
			clr_val_q    <= FREE_MARK;
			root_q       <= 32'(LEAF_COUNT);
			cmp_vld_q    <= 1'b0;
			srch_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == clr_end_q) begin
					clr_cnt_q <= clr_cnt_q >> 1;
					clr_end_q <= clr_end_q + (clr_cnt_q >> 1);
					clr_val_q <= clr_val_q <<< 1;
				end
			end
			if (state_q == ST_IDLE) begin
				srch_q    <= '0;
				cmp_vld_q <= 1'b0;
			end else if (state_q == ST_SEARCH) begin
				if (!srch_q[AW-1]) srch_q <= srch_q + AW'(1);
				cmp_vld_q <= !srch_q[AW-1];
			end
			if (state_q == ST_SIB_ADD && op_q != OP_PATH && top_level) begin
				root_q <= alu.sum;
			end
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (emit) result <= emit_beat;
		case (state_q)
			ST_IDLE: begin
				op_q     <= cmd.operation;
				value_q  <= cmd.leaf_value;
				target_q <= (cmd.operation == OP_ADD) ? FREE_MARK : cmd.leaf_value;
			end
			ST_SEARCH: begin
				cmp_idx_q <= srch_q[LW-1:0];
				if (found) begin
					leaf_q <= cmp_idx_q;
					pos_q  <= cmp_idx_q;
					off_q  <= '0;
					cnt_q  <= AW'(LEAF_COUNT);
					cur_q  <= (op_q == OP_DEL) ? FREE_MARK : value_q;
				end
			end
			ST_SIB_ADD: begin
				cur_q <= alu.sum;
				off_q <= off_q + cnt_q;
				cnt_q <= cnt_q >> 1;
				pos_q <= pos_q >> 1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sum tree slot store: add, delete and path reads.
// ----------------------------------------------------------------------------
// A queue of commands is filled once at time zero: a short directed list
// that covers the extremes, every operation and the corner cases, then
// several hundred random commands drawn mostly from a small pool of values
// so that deletes and path reads actually hit leaves. A driver presents the
// commands in bursts with random gaps. A monitor keeps a private copy of the
// tree, predicts the result beats of every accepted command and compares
// each strobed result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;
	import smt_pkg::*;

	localparam int LEVELS      = 5;
	localparam int LEAF_COUNT  = 1 << (LEVELS - 1);
	localparam int NODE_COUNT  = (1 << LEVELS) - 1;
	localparam int ROOT        = NODE_COUNT - 1;
	localparam int RANDOM_CMDS = 320;
	localparam int POOL_SIZE   = 12;
	// The limit covers the slowest commands, the pauses between bursts and
	// the one clearing pass with a wide margin.
	localparam int CYCLE_LIMIT = 200000;
	// Drain time after the last expected beat, so that a stray extra beat
	// is still caught by the monitor.
	localparam int DRAIN_CYCLES = 60;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_beat_t  cmd = '0;
	logic      busy;
	logic      result_valid;
	out_beat_t result;

	// Commands waiting to be presented, and result beats owed by the block.
	in_beat_t  cmd_backlog[$];
	out_beat_t owed_results[$];

	// Private copy of the node store: leaves first, then each level above,
	// root last.
	logic [31:0] tree_words [NODE_COUNT];

	logic        took_beat = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	sum_merkle_tree_slot_store #(
		.TREE_LEVELS(LEVELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Rebuild the sums on the path from one leaf up to the root.
	task automatic refresh_sums(input int leaf);
		int off;
		int cnt;
		int pos;
		off = 0;
		cnt = LEAF_COUNT;
		pos = leaf;
		while (cnt > 1) begin
			tree_words[off + cnt + (pos >> 1)] =
				tree_words[off + (pos & ~1)] + tree_words[off + (pos | 1)];
			off += cnt;
			cnt >>= 1;
			pos >>= 1;
		end
	endtask

	// Append one beat to the list of beats the block still owes.
	task automatic owe_beat(input out_beat_t b);
		owed_results = {owed_results, b};
	endtask

	// Apply one accepted command to the private tree and queue the result
	// beats that the block owes for it.
	task automatic apply_tree_op(input in_beat_t c);
		logic [31:0] wanted;
		out_beat_t   beat;
		int          leaf;
		int          i;
		int          off;
		int          cnt;
		int          pos;
		// The unknown opcode is silently dropped by the block.
		if (c.operation == OP_NONE)
			return;
		// Add looks for the first free leaf; the others look for the value.
		wanted = (c.operation == OP_ADD) ? FREE_MARK : c.leaf_value;
		leaf = LEAF_COUNT;
		for (i = LEAF_COUNT - 1; i >= 0; i--) begin
			if (tree_words[i] == wanted)
				leaf = i;
		end
		beat = '0;
		beat.last = 1'b1;
		if (leaf == LEAF_COUNT) begin
			// Full tree or missing value: a single status beat, no change.
			beat.status = (c.operation == OP_ADD) ? STAT_FULL : STAT_MISSING;
			beat.root_sum = tree_words[ROOT];
			owe_beat(beat);
			return;
		end
		beat.status = STAT_OK;
		beat.leaf_index = leaf[3:0];
		if (c.operation != OP_PATH) begin
			// Adding the value one rewrites a free leaf with one, which
			// leaves every sum as it was; the beat still names that leaf.
			tree_words[leaf] = (c.operation == OP_ADD) ? c.leaf_value : FREE_MARK;
			refresh_sums(leaf);
			beat.root_sum = tree_words[ROOT];
			owe_beat(beat);
			return;
		end
		// Path read: one beat per level, bottom pair first.
		beat.root_sum = tree_words[ROOT];
		off = 0;
		cnt = LEAF_COUNT;
		pos = leaf;
		while (cnt > 1) begin
			beat.left_value = tree_words[off + (pos & ~1)];
			beat.right_value = tree_words[off + (pos | 1)];
			beat.parent_value = tree_words[off + cnt + (pos >> 1)];
			beat.path_is_right = pos[0];
			beat.last = (cnt == 2);
			owe_beat(beat);
			off += cnt;
			cnt >>= 1;
			pos >>= 1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_cmd(input logic [1:0] op, input logic [31:0] value);
		in_beat_t c;
		c.operation = op;
		c.leaf_value = value;
		cmd_backlog = {cmd_backlog, c};
	endtask

	// Monitor: the block cannot be held off, so every strobed beat is
	// checked at the edge that ends its cycle. A beat taken at this edge
	// is predicted here too; its own results can only come later.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid) begin
			if (owed_results.size() == 0) begin
				$error("result beat with nothing expected: %p", result);
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				check_field("status", want.status, result.status);
				check_field("leaf_index", want.leaf_index, result.leaf_index);
				check_field("root_sum", want.root_sum, result.root_sum);
				check_field("left_value", want.left_value, result.left_value);
				check_field("right_value", want.right_value, result.right_value);
				check_field("parent_value", want.parent_value, result.parent_value);
				check_field("path_is_right", want.path_is_right, result.path_is_right);
				check_field("last", want.last, result.last);
			end
		end
		if (arst_n && start && !busy)
			apply_tree_op(cmd);
		took_beat <= arst_n && start && !busy;
	end

	// Driver: a command stays on the bus until it is taken. Commands go out
	// in bursts; once a burst has been taken the sender may pause a while.
	// Some bursts end without any pause, so back-to-back stretches occur.
	always @(negedge clk) begin
		if (arst_n && (!start || took_beat)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_backlog.size() > 0) begin
				cmd <= cmd_backlog.pop_front();
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Watchdog: a hung block or a lost beat ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] value_pool [POOL_SIZE];
		logic [31:0] edge_values [6];
		in_beat_t    c;
		int          i;
		int          pick;
		int          real_cmds;

		// Tree as it stands after the clearing pass: every leaf free and
		// each inner node the sum of its children.
		for (i = 0; i < LEAF_COUNT; i++)
			tree_words[i] = FREE_MARK;
		for (i = 0; i < LEAF_COUNT - 1; i++)
			tree_words[LEAF_COUNT + i] = tree_words[2 * i] + tree_words[2 * i + 1];

		// Directed part. On the fresh tree: a path read of the free marker
		// itself, misses for delete and path read, the unused opcode, a
		// delete of the free marker, and adding the value one.
		queue_cmd(OP_PATH, FREE_MARK);
		queue_cmd(OP_DEL, 32'h7FFF_FFFF);
		queue_cmd(OP_PATH, 32'h8000_0000);
		queue_cmd(OP_NONE, 32'hFFFF_FFFF);
		queue_cmd(OP_DEL, FREE_MARK);
		queue_cmd(OP_ADD, FREE_MARK);
		// Fill every leaf, starting with the extreme values, so that the
		// root wraps around; then one more add must report a full tree.
		edge_values[0] = 32'h7FFF_FFFF;
		edge_values[1] = 32'h8000_0000;
		edge_values[2] = 32'h0000_0000;
		edge_values[3] = 32'hFFFF_FFFF;
		edge_values[4] = 32'hAAAA_AAAA;
		edge_values[5] = 32'h5555_5555;
		for (i = 0; i < LEAF_COUNT; i++) begin
			if (i < 6)
				queue_cmd(OP_ADD, edge_values[i]);
			else
				queue_cmd(OP_ADD, {31'($urandom_range(1, 32'h7FFF_FFFF)), 1'b0});
		end
		queue_cmd(OP_ADD, 32'h1234_5678);
		// On the full tree: a path read of a right-hand leaf, a delete that
		// frees leaf zero, and a path read that finds the freed leaf.
		queue_cmd(OP_PATH, 32'h8000_0000);
		queue_cmd(OP_DEL, 32'h7FFF_FFFF);
		queue_cmd(OP_PATH, FREE_MARK);

		// Random part. Values come mostly from a small pool, so that the
		// tree fills up and deletes and path reads find their leaves; the
		// rest are fresh values that almost always miss.
		for (i = 0; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;
		value_pool[0] = FREE_MARK;
		real_cmds = 0;
		while (real_cmds < RANDOM_CMDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				c.operation = OP_NONE;
			else if (pick < 45)
				c.operation = OP_ADD;
			else if (pick < 72)
				c.operation = OP_DEL;
			else
				c.operation = OP_PATH;
			if ($urandom_range(0, 6) == 0)
				c.leaf_value = $urandom;
			else
				c.leaf_value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			queue_cmd(c.operation, c.leaf_value);
			if (c.operation != OP_NONE)
				real_cmds++;
		end

		// Reset once; the block then runs its clearing pass with busy high.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every command has been taken and every beat has come.
		while (cmd_backlog.size() != 0 || start)
			@(negedge clk);
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && owed_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
